/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed unit pool allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int MaxBlocks   = 16;
  localparam int SlotW       = 4;
  localparam int MaxUnits    = 64;
  localparam int UnitW       = 6;
  localparam int AlignBytes  = 8;
  localparam int CheckPeriod = 15;
  localparam int IdleLimit   = 300;

  localparam logic [1:0] ModeFetch   = 2'd0;
  localparam logic [1:0] ModeRecycle = 2'd1;
  localparam logic [1:0] ModeCheck   = 2'd2;

  localparam logic [1:0] RegUnitSize = 2'd0;
  localparam logic [1:0] RegUpb      = 2'd1;
  localparam logic [1:0] RegBase     = 2'd2;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNoCfg     = 3'd1,
    StExhausted = 3'd2,
    StBadAddr   = 3'd3,
    StDouble    = 3'd4
  } status_e;

  typedef struct packed {
    logic [17:0] usize;
    logic [6:0]  upb;
    logic [31:0] base;
  } cfg_t;

endpackage

/* rtl/fixed_unit_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_unit_pool_allocator
// Pool of equal-sized units in up to 16 blocks with per-block recycle queues.
// ----------------------------------------------------------------------------
// Usage: program unit_size, units_per_block and pool_base over APB while no
// block is live. Raise start with mode_i, unit_addr_i and now_seconds_i; the
// command transfers when start is high and busy is low. busy stays high until
// done_o pulses for one cycle with status and the pool counters.
// Operation: fetch scans slots one slot per cycle, then uses the shared
// multiplier for the address. Recycle finds the slot and unit index of a
// good address by repeated add and subtract against block and unit size,
// then runs the idle check it triggers, which scans slots. The idle check
// scans one slot per cycle. One command at a time.
// Reset clears all block state and counters; the recycle queue memory is not
// cleared. The receiver cannot stall: results are valid only while done_o.
// ----------------------------------------------------------------------------
module fixed_unit_pool_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] unit_addr_i,
  input  logic [31:0] now_seconds_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_addr_o,
  output logic [10:0] units_allocated_o,
  output logic [10:0] units_consumed_o,
  output logic [10:0] units_free_o,
  output logic [4:0]  blocks_live_o
);
  import fpa_pkg::*;

  typedef enum logic [14:0] {
    SIdle    = 15'b000000000000001,
    SFScan   = 15'b000000000000010,
    STake    = 15'b000000000000100,
    SRing    = 15'b000000000001000,
    SUpd     = 15'b000000000010000,
    SMul1    = 15'b000000000100000,
    SMul2    = 15'b000000001000000,
    SAddr    = 15'b000000010000000,
    SBsize   = 15'b000000100000000,
    SRScan   = 15'b000001000000000,
    SRDiv    = 15'b000010000000000,
    SRChk    = 15'b000100000000000,
    SChk     = 15'b001000000000000,
    SChkScan = 15'b010000000000000,
    SDone    = 15'b100000000000000
  } state_e;

  cfg_t cfg;
  state_e state_q, state_d;

  logic              live_q  [MaxBlocks];
  logic [6:0]        fresh_q [MaxBlocks];
  logic [UnitW-1:0]  head_q  [MaxBlocks];
  logic [6:0]        cnt_q   [MaxBlocks];
  logic [MaxUnits-1:0] bmp_q [MaxBlocks];
  logic [6:0]        fc_q    [MaxBlocks];
  logic [31:0]       stamp_q [MaxBlocks];

  logic [UnitW-1:0]  ring_mem [MaxBlocks*MaxUnits];
  logic [UnitW-1:0]  ring_rd_q;

  logic [10:0] alloc_q, cons_q, free_q;
  logic [4:0]  blocks_q;
  logic [31:0] last_q;

  logic [31:0] addr_q, now_q, off_q, granted_q;
  logic [SlotW-1:0] s_q, empty_q;
  logic        have_empty_q;
  logic [UnitW-1:0] idx_q;
  logic [27:0] acc_q;
  logic [23:0] wofs_q;
  status_e     status_q;

  logic        mul_en;
  logic [10:0] mul_a;
  logic [17:0] mul_b;
  logic [28:0] mul_p;

  logic        last_slot;
  logic [27:0] acc_next;
  logic [23:0] bsize;
  logic [MaxUnits-1:0] full_mask;
  logic        ring_we;
  logic [SlotW+UnitW-1:0] ring_waddr, ring_raddr;

  fpa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lock_i  (blocks_q != 5'd0),
    .cfg_o   (cfg)
  );

  fpa_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign last_slot = (s_q == SlotW'(MaxBlocks - 1));
  assign bsize     = mul_p[23:0];
  assign acc_next  = acc_q + 28'(bsize);
  assign full_mask = {MaxUnits{1'b1}} >> (7'(MaxUnits) - cfg.upb);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      SBsize: begin
        mul_en = 1'b1;
        mul_a  = 11'(cfg.upb);
        mul_b  = cfg.usize;
      end
      SMul1: begin
        mul_en = 1'b1;
        mul_a  = 11'(s_q);
        mul_b  = 18'(cfg.upb);
      end
      SMul2: begin
        mul_en = 1'b1;
        mul_a  = mul_p[10:0] + 11'(idx_q);
        mul_b  = cfg.usize;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (start) begin
          if (mode_i == ModeCheck) state_d = SChk;
          else if (mode_i != ModeFetch && mode_i != ModeRecycle) state_d = SDone;
          else if (cfg.usize == 18'd0) state_d = SDone;
          else if (mode_i == ModeFetch) state_d = SFScan;
          else state_d = SBsize;
        end
      end
      SFScan: begin
        if (live_q[s_q] && fc_q[s_q] != 7'd0) state_d = STake;
        else if (last_slot) begin
          if (have_empty_q || !live_q[s_q]) state_d = STake;
          else state_d = SDone;
        end
      end
      STake:    state_d = (fresh_q[s_q] < cfg.upb) ? SUpd : SRing;
      SRing:    state_d = SUpd;
      SUpd:     state_d = SMul1;
      SMul1:    state_d = SMul2;
      SMul2:    state_d = SAddr;
      SAddr:    state_d = SDone;
      SBsize:   state_d = SRScan;
      SRScan: begin
        if ({1'b0, off_q} < 33'(acc_next)) state_d = live_q[s_q] ? SRDiv : SDone;
        else if (last_slot) state_d = SDone;
      end
      SRDiv: begin
        if (wofs_q < 24'(cfg.usize)) state_d = (wofs_q == 24'd0) ? SRChk : SDone;
      end
      SRChk:    state_d = bmp_q[s_q][idx_q] ? SDone : SChk;
      SChk:     state_d = ((now_q - last_q) < 32'(CheckPeriod)) ? SDone : SChkScan;
      SChkScan: begin
        if (free_q <= 11'(cfg.upb) || s_q == '0) state_d = SDone;
      end
      SDone:    state_d = SIdle;
      default:  state_d = SIdle;
    endcase
  end

  assign ring_raddr = {s_q, head_q[s_q]};
  assign ring_waddr = {s_q, head_q[s_q] + cnt_q[s_q][UnitW-1:0]};
  assign ring_we    = (state_q == SRChk) && !bmp_q[s_q][idx_q];

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_waddr] <= idx_q;
    ring_rd_q <= ring_mem[ring_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      alloc_q      <= '0;
      cons_q       <= '0;
      free_q       <= '0;
      blocks_q     <= '0;
      last_q       <= '0;
      status_q     <= StOk;
      s_q          <= '0;
      empty_q      <= '0;
      have_empty_q <= 1'b0;
      for (int i = 0; i < MaxBlocks; i++) begin
        live_q[i]  <= 1'b0;
        fresh_q[i] <= '0;
        head_q[i]  <= '0;
        cnt_q[i]   <= '0;
        bmp_q[i]   <= '0;
        fc_q[i]    <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        SIdle: begin
          if (start) begin
            addr_q       <= unit_addr_i;
            now_q        <= now_seconds_i;
            granted_q    <= '0;
            s_q          <= '0;
            have_empty_q <= 1'b0;
            acc_q        <= '0;
            idx_q        <= '0;
            if ((mode_i == ModeFetch || mode_i == ModeRecycle) && cfg.usize == 18'd0) begin
              status_q <= StNoCfg;
            end else begin
              status_q <= StOk;
            end
          end
        end
        SFScan: begin
          if (live_q[s_q] && fc_q[s_q] != 7'd0) begin
            s_q <= s_q;
          end else if (last_slot) begin
            if (have_empty_q || !live_q[s_q]) begin
              automatic logic [SlotW-1:0] e = have_empty_q ? empty_q : s_q;
              s_q        <= e;
              live_q[e]  <= 1'b1;
              fresh_q[e] <= '0;
              head_q[e]  <= '0;
              cnt_q[e]   <= '0;
              bmp_q[e]   <= full_mask;
              fc_q[e]    <= cfg.upb;
              stamp_q[e] <= now_q;
              alloc_q    <= alloc_q + 11'(cfg.upb);
              free_q     <= free_q + 11'(cfg.upb);
              blocks_q   <= blocks_q + 5'd1;
            end else begin
              status_q <= StExhausted;
            end
          end else begin
            if (!live_q[s_q] && !have_empty_q) begin
              empty_q      <= s_q;
              have_empty_q <= 1'b1;
            end
            s_q <= s_q + 1'b1;
          end
        end
        STake: begin
          if (fresh_q[s_q] < cfg.upb) begin
            idx_q        <= fresh_q[s_q][UnitW-1:0];
            fresh_q[s_q] <= fresh_q[s_q] + 7'd1;
          end else begin
            head_q[s_q] <= head_q[s_q] + 1'b1;
            if (cnt_q[s_q] != 7'd0) cnt_q[s_q] <= cnt_q[s_q] - 7'd1;
          end
        end
        SRing: idx_q <= ring_rd_q;
        SUpd: begin
          bmp_q[s_q][idx_q] <= 1'b0;
          if (fc_q[s_q] != 7'd0) fc_q[s_q] <= fc_q[s_q] - 7'd1;
          stamp_q[s_q] <= now_q;
          cons_q       <= cons_q + 11'd1;
          if (free_q != 11'd0) free_q <= free_q - 11'd1;
        end
        SAddr: granted_q <= cfg.base + 32'(mul_p);
        SBsize: off_q <= addr_q - cfg.base;
        SRScan: begin
          if ({1'b0, off_q} < 33'(acc_next)) begin
            wofs_q <= 24'(off_q - 32'(acc_q));
            if (!live_q[s_q]) status_q <= StBadAddr;
          end else begin
            acc_q <= acc_next;
            s_q   <= s_q + 1'b1;
            if (last_slot) status_q <= StBadAddr;
          end
        end
        SRDiv: begin
          if (wofs_q >= 24'(cfg.usize)) begin
            wofs_q <= wofs_q - 24'(cfg.usize);
            idx_q  <= idx_q + 1'b1;
          end else if (wofs_q != 24'd0) begin
            status_q <= StBadAddr;
          end
        end
        SRChk: begin
          if (bmp_q[s_q][idx_q]) begin
            status_q <= StDouble;
          end else begin
            cnt_q[s_q]        <= cnt_q[s_q] + 7'd1;
            bmp_q[s_q][idx_q] <= 1'b1;
            fc_q[s_q]         <= fc_q[s_q] + 7'd1;
            stamp_q[s_q]      <= now_q;
            free_q            <= free_q + 11'd1;
            if (cons_q != 11'd0) cons_q <= cons_q - 11'd1;
          end
        end
        SChk: s_q <= SlotW'(MaxBlocks - 1);
        SChkScan: begin
          if (free_q <= 11'(cfg.upb)) begin
            last_q <= now_q;
          end else begin
            if (live_q[s_q] && (now_q - stamp_q[s_q]) >= 32'(IdleLimit)
                && fc_q[s_q] == cfg.upb) begin
              live_q[s_q]  <= 1'b0;
              fresh_q[s_q] <= '0;
              head_q[s_q]  <= '0;
              cnt_q[s_q]   <= '0;
              bmp_q[s_q]   <= '0;
              fc_q[s_q]    <= '0;
              alloc_q  <= (alloc_q >= 11'(cfg.upb)) ? alloc_q - 11'(cfg.upb) : 11'd0;
              free_q   <= free_q - 11'(cfg.upb);
              blocks_q <= blocks_q - 5'd1;
            end
            if (s_q == '0) last_q <= now_q;
            else s_q <= s_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy              = (state_q != SIdle);
  assign done_o            = (state_q == SDone);
  assign status_o          = status_q;
  assign granted_addr_o    = (status_q == StOk) ? granted_q : 32'd0;
  assign units_allocated_o = alloc_q;
  assign units_consumed_o  = cons_q;
  assign units_free_o      = free_q;
  assign blocks_live_o     = blocks_q;

`ifndef NO_ASSERTIONS
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");
  a_blocks_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocks_q <= 5'(MaxBlocks)) else $error("live block count overflow");
  a_units_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (12'(cons_q) + 12'(free_q) == 12'(alloc_q)))
    else $error("pool counters out of balance");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !done_o) |=> busy) else $error("command dropped before result");
`endif
endmodule

/* rtl/fpa_mul.sv */
// ----------------------------------------------------------------------------
// fpa_mul
// Shared multiplier with registered product, loaded on enable.
// ----------------------------------------------------------------------------
module fpa_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [10:0] a_i,
  input  logic [17:0] b_i,
  output logic [28:0] p_o
);
  logic [28:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 29'(a_i) * 29'(b_i);
    end
  end

  assign p_o = p_q;
endmodule

/* rtl/fpa_cfg.sv */
// ----------------------------------------------------------------------------
// fpa_cfg
// APB register file; writes are dropped while any block is live.
// ----------------------------------------------------------------------------
module fpa_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               lock_i,
  output fpa_pkg::cfg_t      cfg_o
);
  import fpa_pkg::*;

  logic [16:0] usize_q;
  logic [6:0]  upb_q;
  logic [31:0] base_q;
  logic        wr;
  logic [17:0] usize_r;

  assign wr = psel && penable && pwrite && !lock_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usize_q <= '0;
      upb_q   <= 7'd4;
      base_q  <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        RegUnitSize: usize_q <= pwdata[16:0];
        RegUpb:      upb_q   <= pwdata[6:0];
        RegBase:     base_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegUnitSize: prdata = 32'(usize_q);
      RegUpb:      prdata = 32'(upb_q);
      RegBase:     prdata = base_q;
      default:     prdata = '0;
    endcase
  end

  assign pready  = 1'b1;
  assign usize_r = (18'(usize_q) + 18'(AlignBytes - 1)) & ~18'(AlignBytes - 1);

  always_comb begin
    cfg_o.usize = usize_r;
    cfg_o.base  = base_q;
    if (upb_q == 7'd0) cfg_o.upb = 7'd1;
    else if (upb_q > 7'(MaxUnits)) cfg_o.upb = 7'(MaxUnits);
    else cfg_o.upb = upb_q;
  end
endmodule

/* verif/fixed_unit_pool_allocator_tb.sv */
// ----------------------------------------------------------------------------
// fixed_unit_pool_allocator_tb
// Self-checking bench for the unit pool allocator. Registers are written over
// APB while the pool is empty, a table of directed commands runs first, then
// random fetch, recycle and idle-check traffic with random start gaps. Every
// result is checked against a cycle-free model of the pool kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_unit_pool_allocator_tb;
  import fpa_pkg::*;

  typedef struct {
    status_e     st;
    logic [31:0] addr;
    logic [10:0] alloc;
    logic [10:0] cons;
    logic [10:0] free_n;
    logic [4:0]  live;
  } pool_result_t;

  typedef struct {
    logic [1:0]  mode;
    bit          rel;
    logic [31:0] addr;
    logic [31:0] offs;
    logic [31:0] now;
    bit          typed;
    status_e     st;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = ModeCheck;
  logic [31:0] unit_addr_i = '0;
  logic [31:0] now_seconds_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] granted_addr_o;
  logic [10:0] units_allocated_o, units_consumed_o, units_free_o;
  logic [4:0]  blocks_live_o;

  fixed_unit_pool_allocator dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // pool model state
  logic [16:0] cfg_usize = '0;
  logic [6:0]  cfg_upb = 7'd4;
  logic [31:0] cfg_base = '0;
  bit          slot_live [MaxBlocks];
  int          fresh_idx [MaxBlocks];
  int          ring_idx [MaxBlocks][MaxUnits];
  int          ring_rd [MaxBlocks];
  int          ring_len [MaxBlocks];
  logic [63:0] free_map [MaxBlocks];
  int          slot_free [MaxBlocks];
  logic [31:0] slot_stamp [MaxBlocks];
  int          tot_alloc, tot_cons, tot_free;
  logic [31:0] last_sweep;

  pool_result_t expected_q[$];
  logic [31:0]  granted_q[$];
  logic [31:0]  returned_q[$];
  int           err_count = 0;
  int           quiet_cycles = 0;
  int           item_no = 0;

  function automatic int upb_eff();
    if (cfg_upb < 1) return 1;
    if (cfg_upb > MaxUnits) return MaxUnits;
    return cfg_upb;
  endfunction

  function automatic logic [31:0] usize_eff();
    return ((32'(cfg_usize) + 32'd7) >> 3) << 3;
  endfunction

  function automatic int live_slots();
    int c = 0;
    for (int s = 0; s < MaxBlocks; s++) c += slot_live[s];
    return c;
  endfunction

  function automatic void wipe_slot(int s);
    slot_live[s] = 0;
    fresh_idx[s] = 0;
    ring_rd[s] = 0;
    ring_len[s] = 0;
    free_map[s] = '0;
    slot_free[s] = 0;
  endfunction

  function automatic logic [31:0] take_from_slot(int s, logic [31:0] now);
    int idx;
    if (fresh_idx[s] < upb_eff()) begin
      idx = fresh_idx[s];
      fresh_idx[s]++;
    end else begin
      idx = ring_idx[s][ring_rd[s]];
      ring_rd[s] = (ring_rd[s] + 1) % MaxUnits;
      if (ring_len[s] > 0) ring_len[s]--;
    end
    idx = idx % MaxUnits;
    free_map[s][idx] = 1'b0;
    if (slot_free[s] > 0) slot_free[s]--;
    slot_stamp[s] = now;
    tot_cons++;
    if (tot_free > 0) tot_free--;
    return cfg_base + 32'(s) * 32'(upb_eff()) * usize_eff() + 32'(idx) * usize_eff();
  endfunction

  function automatic status_e fetch_unit(logic [31:0] now, output logic [31:0] addr);
    addr = '0;
    for (int s = 0; s < MaxBlocks; s++) begin
      if (slot_live[s] && slot_free[s] > 0) begin
        addr = take_from_slot(s, now);
        return StOk;
      end
    end
    for (int s = 0; s < MaxBlocks; s++) begin
      if (!slot_live[s]) begin
        wipe_slot(s);
        slot_live[s] = 1;
        free_map[s] = upb_eff() >= 64 ? '1 : (64'd1 << upb_eff()) - 64'd1;
        slot_free[s] = upb_eff();
        slot_stamp[s] = now;
        tot_alloc += upb_eff();
        tot_free += upb_eff();
        addr = take_from_slot(s, now);
        return StOk;
      end
    end
    return StExhausted;
  endfunction

  function automatic status_e return_unit(logic [31:0] addr, logic [31:0] now);
    logic [31:0] us, bsize, offs, s, wofs;
    int idx, pos;
    us = usize_eff();
    bsize = 32'(upb_eff()) * us;
    offs = addr - cfg_base;
    s = offs / bsize;
    if (s >= MaxBlocks) return StBadAddr;
    if (!slot_live[s]) return StBadAddr;
    wofs = offs % bsize;
    if (wofs % us != 0) return StBadAddr;
    idx = int'((wofs / us) % MaxUnits);
    if (free_map[s][idx]) return StDouble;
    pos = (ring_rd[s] + ring_len[s]) % MaxUnits;
    ring_idx[s][pos] = idx;
    ring_len[s]++;
    free_map[s][idx] = 1'b1;
    slot_free[s]++;
    slot_stamp[s] = now;
    tot_free++;
    if (tot_cons > 0) tot_cons--;
    return StOk;
  endfunction

  function automatic void sweep_idle(logic [31:0] now);
    int upb = upb_eff();
    logic [31:0] age;
    age = now - last_sweep;
    if (age < CheckPeriod) return;
    for (int i = MaxBlocks; i > 0 && tot_free > upb; i--) begin
      age = now - slot_stamp[i-1];
      if (slot_live[i-1] && age >= IdleLimit && slot_free[i-1] == upb) begin
        wipe_slot(i - 1);
        tot_alloc = tot_alloc >= upb ? tot_alloc - upb : 0;
        tot_free = tot_free >= upb ? tot_free - upb : 0;
      end
    end
    last_sweep = now;
  endfunction

  function automatic pool_result_t pool_step(logic [1:0] mode, logic [31:0] addr,
                                             logic [31:0] now);
    pool_result_t r;
    logic [31:0] g = '0;
    r.st = StOk;
    if (mode == ModeFetch) begin
      if (usize_eff() == 0) r.st = StNoCfg;
      else r.st = fetch_unit(now, g);
    end else if (mode == ModeRecycle) begin
      if (usize_eff() == 0) r.st = StNoCfg;
      else begin
        r.st = return_unit(addr, now);
        if (r.st == StOk) sweep_idle(now);
      end
    end else if (mode == ModeCheck) begin
      sweep_idle(now);
    end
    r.addr = r.st == StOk ? g : '0;
    r.alloc = 11'(tot_alloc);
    r.cons = 11'(tot_cons);
    r.free_n = 11'(tot_free);
    r.live = 5'(live_slots());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (live_slots() == 0) begin
      case (idx)
        RegUnitSize: cfg_usize = val[16:0];
        RegUpb: cfg_upb = val[6:0];
        RegBase: cfg_base = val;
        default: ;
      endcase
    end
    @(posedge clk_i);
  endtask

  // hold one command until it transfers, then predict its result
  task automatic send_cmd(logic [1:0] mode, logic [31:0] addr, logic [31:0] now,
                          bit typed, status_e st, bit gaps);
    pool_result_t r;
    if (gaps && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= mode;
    unit_addr_i <= addr;
    now_seconds_i <= now;
    do @(posedge clk_i); while (busy);
    r = pool_step(mode, addr, now);
    if (typed) begin
      if (r.st != st) report_mismatch("model status vs table", r.st, st);
      r.st = st;
    end
    if (mode == ModeFetch && r.st == StOk) granted_q.push_back(r.addr);
    expected_q.push_back(r);
    item_no++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    pool_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(status_o), 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (status_o != e.st) report_mismatch("status", status_o, e.st);
        if (granted_addr_o != e.addr) report_mismatch("granted_addr", granted_addr_o, e.addr);
        if (units_allocated_o != e.alloc)
          report_mismatch("units_allocated", units_allocated_o, e.alloc);
        if (units_consumed_o != e.cons)
          report_mismatch("units_consumed", units_consumed_o, e.cons);
        if (units_free_o != e.free_n) report_mismatch("units_free", units_free_o, e.free_n);
        if (blocks_live_o != e.live) report_mismatch("blocks_live", blocks_live_o, e.live);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  cmd_row_t cold_rows[] = '{
    '{ModeFetch,   0, 32'h0,        0, 32'h0,        1, StNoCfg},
    '{ModeRecycle, 0, 32'hFFFFFFFF, 0, 32'h5,        1, StNoCfg},
    '{ModeRecycle, 0, 32'h0,        0, 32'h9,        1, StNoCfg},
    '{ModeCheck,   0, 32'h0,        0, 32'h0,        1, StOk},
    '{ModeCheck,   0, 32'h0,        0, 32'hFFFFFFFF, 1, StOk},
    '{2'd3,        0, 32'hFFFFFFFF, 0, 32'h0,        1, StOk}
  };

  cmd_row_t warm_rows[] = '{
    '{ModeFetch,   0, 32'h0,        0, 32'h100,      1, StOk},
    '{ModeFetch,   0, 32'h0,        0, 32'h101,      1, StOk},
    '{ModeRecycle, 1, 32'd0,        0, 32'h102,      1, StOk},
    '{ModeRecycle, 1, 32'd0,        0, 32'h103,      1, StDouble},
    '{ModeRecycle, 1, 32'd1,        4, 32'h104,      1, StBadAddr},
    '{ModeRecycle, 1, 32'd0,        32'hFFFFFFF8, 32'h105, 1, StBadAddr},
    '{ModeRecycle, 0, 32'hFFFFFFFF, 0, 32'h106,      0, StOk},
    '{ModeRecycle, 0, 32'h0,        0, 32'h107,      0, StOk},
    '{ModeFetch,   0, 32'h0,        0, 32'hFFFFFFFF, 1, StOk},
    '{ModeFetch,   0, 32'h0,        0, 32'h0,        1, StOk},
    '{2'd3,        0, 32'h0,        0, 32'h200,      1, StOk},
    '{ModeCheck,   0, 32'h0,        0, 32'h8000,     0, StOk},
    '{ModeRecycle, 1, 32'd1,        0, 32'h9000,     0, StOk}
  };

  initial begin
    logic [31:0] tnow, a;
    int pick, k;
    for (int s = 0; s < MaxBlocks; s++) begin
      wipe_slot(s);
      slot_stamp[s] = '0;
    end
    tot_alloc = 0;
    tot_cons = 0;
    tot_free = 0;
    last_sweep = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cold_rows[i])
      send_cmd(cold_rows[i].mode, cold_rows[i].addr, cold_rows[i].now,
               cold_rows[i].typed, cold_rows[i].st, 0);

    // empty-pool settings: recycles and checks leave the pool empty
    for (int p = 0; p < 3; p++) begin
      drain();
      reg_write(RegUnitSize, p == 0 ? 32'h1FFFF : (p == 1 ? 32'd1 : 32'd65536));
      reg_write(RegUpb, p == 0 ? 32'd0 : (p == 1 ? 32'd127 : 32'd64));
      reg_write(RegBase, p == 0 ? 32'hFFFFFFFF : (p == 1 ? 32'h0 : 32'h80000000));
      for (int i = 0; i < 4; i++)
        send_cmd(i[0] ? ModeCheck : ModeRecycle, $urandom, $urandom, 0, StOk, 1);
    end

    drain();
    reg_write(RegUnitSize, $urandom_range(0, 3) == 0 ? 32'd65536 : $urandom_range(1, 200));
    reg_write(RegUpb, $urandom_range(0, 7) == 0 ? 32'd64 : $urandom_range(1, 6));
    reg_write(RegBase, $urandom);

    foreach (warm_rows[i]) begin
      a = warm_rows[i].rel ? cfg_base + warm_rows[i].addr * usize_eff() + warm_rows[i].offs
                           : warm_rows[i].addr;
      send_cmd(warm_rows[i].mode, a, warm_rows[i].now, warm_rows[i].typed,
               warm_rows[i].st, 0);
    end
    granted_q.delete();

    tnow = 32'hFFFFFE00;
    for (int n = 0; n < 1400; n++) begin
      k = $urandom_range(0, 199);
      if (k == 0) tnow = $urandom;
      else if (k < 8) tnow += $urandom_range(300, 2000);
      else tnow += $urandom_range(0, 20);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_cmd(ModeFetch, $urandom, tnow, 0, StOk, n < 600 || n > 800);
      end else if (pick < 75 && granted_q.size() != 0) begin
        k = $urandom_range(0, granted_q.size() - 1);
        a = granted_q[k];
        granted_q.delete(k);
        returned_q.push_back(a);
        if (returned_q.size() > 16) void'(returned_q.pop_front());
        send_cmd(ModeRecycle, a, tnow, 0, StOk, n < 600 || n > 800);
      end else if (pick < 80 && returned_q.size() != 0) begin
        a = returned_q[$urandom_range(0, returned_q.size() - 1)];
        send_cmd(ModeRecycle, a, tnow, 0, StOk, n < 600 || n > 800);
      end else if (pick < 88) begin
        a = granted_q.size() != 0 ? granted_q[0] + $urandom_range(1, 7) : $urandom;
        send_cmd(ModeRecycle, pick[0] ? a : $urandom, tnow, 0, StOk, n < 600 || n > 800);
      end else if (pick < 98) begin
        send_cmd(ModeCheck, $urandom, tnow, 0, StOk, n < 600 || n > 800);
      end else begin
        send_cmd(2'd3, $urandom, $urandom, 0, StOk, n < 600 || n > 800);
      end
    end

    drain();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
